/* hw/rtl/wsom_pkg.sv */
// Shared types, constants and codes for the windowed sample offset map.
package wsom_pkg;

  localparam int MAX_WINDOWS = 256;
  localparam int OFFSET_BITS = 32;
  localparam int WIN_AW      = $clog2(MAX_WINDOWS);
  localparam int SIZE_BITS   = 16;
  localparam int COUNT_BITS  = 9;
  localparam int PROD_BITS   = SIZE_BITS + COUNT_BITS;
  localparam int QDEPTH      = 2;
  localparam int QAW         = $clog2(QDEPTH);

  localparam logic [1:0] KIND_LOAD = 2'd0;
  localparam logic [1:0] KIND_FWD  = 2'd1;
  localparam logic [1:0] KIND_REV  = 2'd2;

  localparam logic REG_SIZE  = 1'b0;
  localparam logic REG_COUNT = 1'b1;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  entry_slot;
    logic [31:0] operand;
  } in_item_t;

  typedef struct packed {
    logic [31:0] answer;
    logic        out_of_range;
  } out_item_t;

  typedef enum logic [1:0] {
    OP_NOP,
    OP_LOAD,
    OP_FWD,
    OP_REV
  } op_e;

  typedef struct packed {
    op_e                    op;
    logic [WIN_AW-1:0]      slot;
    logic [OFFSET_BITS-1:0] operand;
  } qitem_t;

  // Effective configuration: size never zero, count never beyond the table.
  typedef struct packed {
    logic [SIZE_BITS-1:0]  size;
    logic [COUNT_BITS-1:0] count;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_FWD_CHK,
    ST_FWD_DIV,
    ST_FWD_RD,
    ST_FWD_ADD,
    ST_REV_ADDR,
    ST_REV_CMP,
    ST_REV_MUL,
    ST_REV_ADD,
    ST_EMIT
  } state_e;

endpackage

/* hw/rtl/wsom_ram.sv */
// Generic single write port, single read port RAM with registered read data.
module wsom_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/wsom_div.sv */
// Restoring divider, one quotient bit per cycle.
module wsom_div import wsom_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [OFFSET_BITS-1:0] dividend_i,
  input  logic [SIZE_BITS-1:0]   divisor_i,
  output logic                   done_o,
  output logic [OFFSET_BITS-1:0] quotient_o,
  output logic [SIZE_BITS-1:0]   remainder_o
);

  localparam int CW = $clog2(OFFSET_BITS);

  logic [OFFSET_BITS-1:0] dvd_q, dvd_d;
  logic [SIZE_BITS-1:0]   rem_q, rem_d;
  logic [CW-1:0]          cnt_q;
  logic                   busy_q, done_q;
  logic [SIZE_BITS:0]     trial, diff;
  logic                   ge;

  always_comb begin
    trial = {rem_q, dvd_q[OFFSET_BITS-1]};
    diff  = trial - {1'b0, divisor_i};
    ge    = trial >= {1'b0, divisor_i};
    // The trial stays below twice the divisor, so the difference fits.
    rem_d = ge ? diff[SIZE_BITS-1:0] : trial[SIZE_BITS-1:0];
    dvd_d = {dvd_q[OFFSET_BITS-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == CW'(OFFSET_BITS - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= dvd_d;
      rem_q <= rem_d;
    end
  end

  assign done_o      = done_q;
  assign quotient_o  = dvd_q;
  assign remainder_o = rem_q;

endmodule

/* hw/rtl/wsom_front.sv */
// Front end: accepts items, classifies them and queues them for the back end.
module wsom_front import wsom_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_item_t in_item_i,
  output logic     q_valid_o,
  output qitem_t   q_item_o,
  input  logic     q_pop_i
);

  qitem_t         fifo_q [QDEPTH];
  logic [QAW-1:0] wptr_q, rptr_q;
  logic [QAW:0]   cnt_q;
  logic           push;
  qitem_t         cls;

  always_comb begin
    cls.slot    = in_item_i.entry_slot[WIN_AW-1:0];
    cls.operand = in_item_i.operand;
    case (in_item_i.kind)
      KIND_LOAD: cls.op = (32'(in_item_i.entry_slot) < MAX_WINDOWS) ? OP_LOAD : OP_NOP;
      KIND_FWD:  cls.op = OP_FWD;
      KIND_REV:  cls.op = OP_REV;
      default:   cls.op = OP_NOP;
    endcase
  end

  assign in_stall_o = (cnt_q == (QAW+1)'(QDEPTH));
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = (cnt_q != '0);
  assign q_item_o   = fifo_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (q_pop_i) begin
        rptr_q <= rptr_q + 1'b1;
      end
      if (push && !q_pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!push && q_pop_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wptr_q] <= cls;
    end
  end

endmodule

/* hw/rtl/wsom_back.sv */
// Back end: carries out loads, forward and reverse mappings, one item at a time.
module wsom_back import wsom_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      q_valid_i,
  input  qitem_t    q_item_i,
  output logic      q_pop_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  state_e state_q, state_d;

  qitem_t                 cur_q;
  logic [PROD_BITS-1:0]   prod_q;
  logic [COUNT_BITS-1:0]  idx_q;
  logic [WIN_AW-1:0]      pick_q;
  logic [OFFSET_BITS-1:0] pick_start_q;
  logic [OFFSET_BITS-1:0] delta_q;
  logic [OFFSET_BITS-1:0] ans_q;
  logic                   oor_q;
  logic                   out_valid_q;
  out_item_t              out_q;

  logic                   ram_we;
  logic [WIN_AW-1:0]      ram_raddr;
  logic [OFFSET_BITS-1:0] ram_rdata;
  logic                   div_start, div_done;
  logic [OFFSET_BITS-1:0] quot;
  logic [SIZE_BITS-1:0]   rem;

  logic                   out_free, in_range, last_entry, below;
  logic [OFFSET_BITS-1:0] diff, size_m1;

  wsom_ram #(
    .WIDTH(OFFSET_BITS),
    .DEPTH(MAX_WINDOWS)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(cur_q.slot),
    .wdata_i(cur_q.operand),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  wsom_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (cur_q.operand),
    .divisor_i  (cfg_i.size),
    .done_o     (div_done),
    .quotient_o (quot),
    .remainder_o(rem)
  );

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_range   = cur_q.operand < OFFSET_BITS'(prod_q);
  assign below      = ram_rdata > cur_q.operand;
  assign last_entry = (idx_q + 1'b1) == cfg_i.count;
  assign diff       = cur_q.operand - pick_start_q;
  assign size_m1    = OFFSET_BITS'(cfg_i.size) - 1'b1;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          case (q_item_i.op)
            OP_LOAD: state_d = ST_LOAD;
            OP_FWD:  state_d = ST_FWD_CHK;
            OP_REV:  state_d = (cfg_i.count == '0) ? ST_EMIT : ST_REV_ADDR;
            default: state_d = ST_EMIT;
          endcase
        end
      end
      ST_LOAD:     state_d = ST_EMIT;
      ST_FWD_CHK:  state_d = in_range ? ST_FWD_DIV : ST_EMIT;
      ST_FWD_DIV:  state_d = div_done ? ST_FWD_RD : ST_FWD_DIV;
      ST_FWD_RD:   state_d = ST_FWD_ADD;
      ST_FWD_ADD:  state_d = ST_EMIT;
      ST_REV_ADDR: state_d = ST_REV_CMP;
      ST_REV_CMP: begin
        if (below && idx_q == '0) begin
          state_d = ST_EMIT;
        end else if (last_entry) begin
          state_d = ST_REV_MUL;
        end else begin
          state_d = ST_REV_ADDR;
        end
      end
      ST_REV_MUL:  state_d = ST_REV_ADD;
      ST_REV_ADD:  state_d = ST_EMIT;
      ST_EMIT:     state_d = out_free ? ST_IDLE : ST_EMIT;
      default:     state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop_o   = 1'b0;
    ram_we    = 1'b0;
    div_start = 1'b0;
    ram_raddr = idx_q[WIN_AW-1:0];
    case (state_q)
      ST_IDLE:    q_pop_o = q_valid_i;
      ST_LOAD:    ram_we = 1'b1;
      ST_FWD_CHK: div_start = in_range;
      ST_FWD_RD:  ram_raddr = quot[WIN_AW-1:0];
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_EMIT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        cur_q  <= q_item_i;
        prod_q <= PROD_BITS'(cfg_i.size) * PROD_BITS'(cfg_i.count);
        idx_q  <= '0;
        pick_q <= '0;
        ans_q  <= '0;
        oor_q  <= 1'b0;
      end
      ST_FWD_CHK: oor_q <= !in_range;
      ST_FWD_ADD: ans_q <= ram_rdata + OFFSET_BITS'(rem);
      ST_REV_CMP: begin
        if (!below) begin
          pick_q       <= idx_q[WIN_AW-1:0];
          pick_start_q <= ram_rdata;
        end
        idx_q <= idx_q + 1'b1;
      end
      ST_REV_MUL: begin
        prod_q  <= PROD_BITS'(pick_q) * PROD_BITS'(cfg_i.size);
        delta_q <= (diff > size_m1) ? size_m1 : diff;
      end
      ST_REV_ADD: ans_q <= OFFSET_BITS'(prod_q) + delta_q;
      ST_EMIT: begin
        if (out_free) begin
          out_q.answer       <= ans_q[31:0];
          out_q.out_of_range <= oor_q;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

/* hw/rtl/windowed_sample_offset_map.sv */
// Top level of the windowed sample offset map: configuration port, front and back ends.
// Items enter a two-deep queue and are carried out one at a time. A forward mapping
// runs the 32 steps of the bit-serial divider; a reverse mapping scans the window
// start table linearly, reading each entry through the RAM's single registered read
// port. Results leave through an output register, so the next item is taken while a
// result waits.
module windowed_sample_offset_map import wsom_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_item_t    in_item_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_item_t   out_item_o
);

  logic [SIZE_BITS-1:0]  size_q;
  logic [COUNT_BITS-1:0] count_q;
  logic                  wr;
  cfg_t                  cfg;
  logic                  q_valid, q_pop;
  qitem_t                q_item;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q  <= SIZE_BITS'(1);
      count_q <= COUNT_BITS'(1);
    end else if (wr) begin
      case (paddr[2])
        REG_SIZE:  size_q  <= pwdata[SIZE_BITS-1:0];
        REG_COUNT: count_q <= pwdata[COUNT_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  assign prdata = (paddr[2] == REG_COUNT) ? 32'(count_q) : 32'(size_q);

  always_comb begin
    cfg.size  = (size_q == '0) ? SIZE_BITS'(1) : size_q;
    cfg.count = (32'(count_q) > MAX_WINDOWS) ? COUNT_BITS'(MAX_WINDOWS) : count_q;
  end

  wsom_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_item_i (in_item_i),
    .q_valid_o (q_valid),
    .q_item_o  (q_item),
    .q_pop_i   (q_pop)
  );

  wsom_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .q_valid_i  (q_valid),
    .q_item_i   (q_item),
    .q_pop_o    (q_pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

endmodule

/* hw/rtl/wsom_checker.sv */
// Port-level checks for the windowed sample offset map, bound to the top level.
module wsom_checker import wsom_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_item_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("stalled result item dropped");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_item_o))
    else $error("stalled result item changed");

  a_oor_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.out_of_range |-> out_item_o.answer == '0)
    else $error("out of range item with a non-zero answer");

  a_reset_quiet: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("result item shown straight after reset");

endmodule

bind windowed_sample_offset_map wsom_checker u_wsom_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_item_o (out_item_o)
);

/* dv/tb_top.sv */
// Self-checking testbench for the windowed sample offset map.
module tb_top;
  import wsom_pkg::*;

  localparam int  LIMIT      = 3000000;
  localparam int  MAX_REPORT = 10;
  localparam logic [2:0] ADDR_SIZE  = {2'b00, REG_SIZE} << 2;
  localparam logic [2:0] ADDR_COUNT = {2'b00, REG_COUNT} << 2;
  localparam logic [1:0] KIND_SPARE = 2'd3;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  in_item_t    in_item_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_item_t   out_item_o;

  windowed_sample_offset_map i_dut (.*);

  always #6 clk_i = ~clk_i;

  // Predictor state, advanced as items are accepted.
  logic [31:0] win_start [MAX_WINDOWS];
  logic [15:0] cfg_size;
  logic [8:0]  cfg_count;
  // Table contents as the stimulus planner sees them, ahead of acceptance.
  logic [31:0] plan_start [MAX_WINDOWS];

  in_item_t  pending_items [$];
  out_item_t expected_results [$];
  int        mismatches = 0, cycles = 0, n_results = 0;
  int        n_kind [4] = '{0, 0, 0, 0};
  int        in_idle = 0, out_idle = 0;
  bit        calm_tail = 1'b0;

  function automatic out_item_t map_item(in_item_t it);
    out_item_t   r;
    logic [63:0] ws, cnt, pick, delta, addr;
    r = '0;
    ws  = (cfg_size == 0) ? 64'd1 : 64'(cfg_size);
    cnt = (cfg_count > MAX_WINDOWS) ? 64'(MAX_WINDOWS) : 64'(cfg_count);
    addr = 64'(it.operand);
    case (it.kind)
      KIND_LOAD: begin
        win_start[it.entry_slot] = it.operand;
      end
      KIND_FWD: begin
        if (addr >= ws * cnt) begin
          r.out_of_range = 1'b1;
        end else begin
          r.answer = 32'(64'(win_start[addr / ws]) + addr % ws);
        end
      end
      KIND_REV: begin
        if (cnt != 0 && addr >= 64'(win_start[0])) begin
          pick = 0;
          for (int i = 0; i < cnt; i++) if (64'(win_start[i]) <= addr) pick = i;
          delta = addr - 64'(win_start[pick]);
          if (delta > ws - 1) delta = ws - 1;
          r.answer = 32'(pick * ws + delta);
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Input side: feeds queued items, with random idle bursts.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_item_i  <= '0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        expected_results.push_back(map_item(in_item_i));
        n_kind[in_item_i.kind]++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (in_idle > 0) begin
          in_idle--;
          in_valid_i <= 1'b0;
        end else if (pending_items.size() > 0) begin
          in_item_i  <= pending_items.pop_front();
          in_valid_i <= 1'b1;
          if (!calm_tail && $urandom_range(0, 7) == 0) in_idle = $urandom_range(1, 13);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Output side: checks each result against the oldest prediction.
  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      cycles++;
      if (out_valid_o && !out_stall_i) begin
        n_results++;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORT)
            $display("unexpected result: answer %h flag %b",
                     out_item_o.answer, out_item_o.out_of_range);
        end else begin
          want = expected_results.pop_front();
          if (out_item_o.answer !== want.answer ||
              out_item_o.out_of_range !== want.out_of_range) begin
            mismatches++;
            if (mismatches <= MAX_REPORT)
              $display("result %0d: expected answer %h flag %b, got answer %h flag %b",
                       n_results, want.answer, want.out_of_range,
                       out_item_o.answer, out_item_o.out_of_range);
          end
        end
      end
      if (out_idle > 0) begin
        out_idle--;
        out_stall_i <= 1'b1;
      end else if (!calm_tail && $urandom_range(0, 7) == 0) begin
        out_idle = $urandom_range(0, 12);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic wait_idle();
    while (pending_items.size() > 0 || in_valid_i || expected_results.size() > 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] addr, logic [31:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (addr == ADDR_SIZE) cfg_size = data[15:0];
    else cfg_count = data[8:0];
  endtask

  function automatic void queue_item(logic [1:0] kind, logic [7:0] slot, logic [31:0] opnd);
    in_item_t it;
    it.kind       = kind;
    it.entry_slot = slot;
    it.operand    = opnd;
    if (kind == KIND_LOAD) plan_start[slot] = opnd;
    pending_items.push_back(it);
  endfunction

  // Sets up one configuration, loads an ascending table over the windows in use
  // and then sends mostly well-formed translations.
  task automatic run_phase(logic [15:0] size, logic [8:0] count, int n_items);
    int          ws, eff, j, pick;
    logic [31:0] start, opnd;
    wait_idle();
    write_reg(ADDR_SIZE, 32'(size));
    write_reg(ADDR_COUNT, 32'(count));
    ws  = (size == 0) ? 1 : int'(size);
    eff = (count > MAX_WINDOWS) ? MAX_WINDOWS : int'(count);
    start = $urandom_range(0, 3) == 0 ? 32'($urandom_range(0, 99))
                                      : 32'($urandom_range(0, 32'h7fff_ffff));
    for (j = 0; j < eff; j++) begin
      queue_item(KIND_LOAD, 8'(j), start);
      start = start + 32'($urandom_range(0, 2 * ws));
    end
    for (j = 0; j < n_items; j++) begin
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
        queue_item(KIND_LOAD, 8'($urandom), $urandom);
      end else if (pick < 9) begin
        queue_item(KIND_SPARE, 8'($urandom), $urandom);
      end else if (pick < 52) begin
        if ($urandom_range(0, 9) == 0 || eff == 0) opnd = $urandom;
        else opnd = 32'($urandom_range(0, ws * eff + ws / 4));
        queue_item(KIND_FWD, 8'($urandom), opnd);
      end else begin
        case ($urandom_range(0, 9))
          0: opnd = $urandom;
          1: opnd = plan_start[0] - 32'($urandom_range(1, 50));
          default: begin
            opnd = (eff == 0) ? plan_start[0]
                              : plan_start[$urandom_range(0, eff - 1)];
            opnd = opnd + 32'($urandom_range(0, ws + ws / 2));
          end
        endcase
        queue_item(KIND_REV, 8'($urandom), opnd);
      end
    end
  endtask

  initial begin
    for (int i = 0; i < MAX_WINDOWS; i++) begin
      win_start[i]  = '0;
      plan_start[i] = '0;
    end
    cfg_size  = 16'd1;
    cfg_count = 9'd1;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: reset configuration, extremes of every field and spare kind.
    queue_item(KIND_LOAD, 8'd0, 32'd0);
    queue_item(KIND_LOAD, 8'd255, 32'hffff_ffff);
    queue_item(KIND_FWD, 8'd255, 32'd0);
    queue_item(KIND_FWD, 8'd0, 32'd1);
    queue_item(KIND_FWD, 8'd0, 32'hffff_ffff);
    queue_item(KIND_REV, 8'd0, 32'd0);
    queue_item(KIND_REV, 8'd255, 32'hffff_ffff);
    queue_item(KIND_SPARE, 8'd255, 32'hffff_ffff);
    queue_item(KIND_SPARE, 8'd0, 32'd0);
    queue_item(KIND_LOAD, 8'd0, 32'h0000_0100);
    queue_item(KIND_REV, 8'd0, 32'h0000_00ff);
    queue_item(KIND_REV, 8'd0, 32'h0000_0100);
    queue_item(KIND_LOAD, 8'd0, 32'hffff_fff0);
    queue_item(KIND_FWD, 8'd0, 32'd0);
    wait_idle();
    // Zero size behaves as one; an empty table flags every forward index.
    write_reg(ADDR_SIZE, 32'd0);
    write_reg(ADDR_COUNT, 32'd0);
    queue_item(KIND_FWD, 8'd0, 32'd0);
    queue_item(KIND_REV, 8'd0, 32'hffff_ffff);
    queue_item(KIND_REV, 8'd0, 32'd0);

    run_phase(16'd1, 9'd1, 60);
    run_phase(16'd0, 9'd4, 60);
    run_phase(16'd65535, 9'd3, 80);
    run_phase(16'd7, 9'd8, 100);
    run_phase(16'd65535, 9'd256, 40);
    run_phase(16'd3, 9'd511, 30);
    run_phase(16'd1, 9'd0, 30);
    for (int p = 0; p < 7; p++)
      run_phase(16'($urandom_range(1, 300)), 9'($urandom_range(1, 16)), 20);
    run_phase(16'($urandom), 9'($urandom_range(2, 12)), 60);
    wait_idle();
    calm_tail = 1'b1;
    run_phase(16'd100, 9'd6, 120);
    wait_idle();
    repeat (40) @(posedge clk_i);

    $display("covered %0d loads, %0d forward, %0d reverse and %0d spare-kind items",
             n_kind[KIND_LOAD], n_kind[KIND_FWD], n_kind[KIND_REV], n_kind[KIND_SPARE]);
    $display("%0d results checked, %0d mismatches", n_results, mismatches);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/wsom_pkg.sv
hw/rtl/wsom_ram.sv
hw/rtl/wsom_div.sv
hw/rtl/wsom_front.sv
hw/rtl/wsom_back.sv
hw/rtl/windowed_sample_offset_map.sv
hw/rtl/wsom_checker.sv
dv/tb_top.sv
